>>> rtl/rws_pkg.sv
`default_nettype none

package rws_pkg;

   localparam int unsigned COUNT_WIDTH_DEF = 16;

   localparam int unsigned ADDR_W    = 48;
   localparam int unsigned STRG_W    = 8;
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned SCOUNT_W  = 16;
   localparam int unsigned REPORT_W  = 32;
   localparam int unsigned UPTIME_W  = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = ADDR_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_ADDRESS = 2'd0,
      CSR_STRENGTH_FLOOR = 2'd1,
      CSR_WINDOW_TICKS   = 2'd2
   } csr_index_type;

   localparam logic [ADDR_W-1:0]        TARGET_ADDRESS_RST = 48'h6813_245B_F942;
   localparam logic signed [STRG_W-1:0] STRENGTH_FLOOR_RST = -8'sd95;
   localparam logic [TICK_W-1:0]        WINDOW_TICKS_RST   = 16'd1000;

   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

endpackage

`default_nettype wire

>>> rtl/rws_if.sv
`default_nettype none

interface rws_req_if
   import rws_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic signed [STRG_W-1:0] strength;
   logic [ADDR_W-1:0]        addr_first;
   logic [ADDR_W-1:0]        addr_second;

   modport source (output valid, output req_type, output strength, output addr_first,
                   output addr_second, input ready);
   modport sink (input valid, input req_type, input strength, input addr_first,
                 input addr_second, output ready);
endinterface

interface rws_rsp_if
   import rws_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [STRG_W-1:0] avg_strength;
   logic signed [STRG_W-1:0] min_strength;
   logic signed [STRG_W-1:0] max_strength;
   logic [SCOUNT_W-1:0]      sample_count;
   logic [REPORT_W-1:0]      report_number;
   logic [UPTIME_W-1:0]      uptime_ticks;

   modport source (output valid, output avg_strength, output min_strength,
                   output max_strength, output sample_count, output report_number,
                   output uptime_ticks, input ready);
   modport sink (input valid, input avg_strength, input min_strength,
                 input max_strength, input sample_count, input report_number,
                 input uptime_ticks, output ready);
endinterface

`default_nettype wire

>>> rtl/rssi_window_statistics.sv
// Windowed min / max / average of received signal strength.
//
// req_chan carries one item per handshake: a received frame or a 1 ms tick.
// A frame whose strength is at or above the floor and whose first or second
// address matches the target is added to the window unless its count is full. A tick advances uptime
// and the window tick counter; when that counter reaches window_ticks the
// window closes and, if it held samples, one item leaves on rsp_chan.
// The csr_ port writes the target address, the strength floor and the window
// length; write only while the block is idle.
//
// req_chan stays ready after frames and ticks that do not close a non-empty window.
// A closing tick starts a restoring divider, one quotient bit per cycle over
// COUNT_WIDTH+8 bits; req_chan is not ready until the result has been
// written to the output register, where it sits. If the receiver stalls, the
// next closing tick waits in the divider until that register frees.
// Reset (synchronous) restores the register defaults and clears all counters
// and accumulators.
`default_nettype none

module rssi_window_statistics
   import rws_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [CSR_DAT_W-1:0]   csr_wdata,
   rws_req_if.sink               req_chan,
   rws_rsp_if.source             rsp_chan
);

   localparam int unsigned SUM_W  = COUNT_WIDTH + STRG_W;
   localparam int unsigned ITER_W = $clog2(SUM_W + 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = {COUNT_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DIVIDE = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]        target_ff, target_in;
   logic signed [STRG_W-1:0] floor_ff, floor_in;
   logic [TICK_W-1:0]        window_ff, window_in;

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic signed [STRG_W-1:0] low_ff, low_in;
   logic signed [STRG_W-1:0] high_ff, high_in;
   logic [TICK_W-1:0]        elapsed_ff, elapsed_in;
   logic [UPTIME_W-1:0]      uptime_ff, uptime_in;
   logic [REPORT_W-1:0]      report_ff, report_in;

   logic [SUM_W-1:0]         dvd_ff, dvd_in;
   logic [COUNT_WIDTH-1:0]   rem_ff, rem_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic                     neg_ff, neg_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [STRG_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic signed [STRG_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [STRG_W-1:0] rsp_max_ff, rsp_max_in;
   logic [SCOUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [REPORT_W-1:0]      rsp_report_ff, rsp_report_in;
   logic [UPTIME_W-1:0]      rsp_uptime_ff, rsp_uptime_in;

   logic                     req_fire;
   logic                     frame_hit;
   logic [TICK_W-1:0]        elapsed_next;
   logic [COUNT_WIDTH:0]     rem_sh;
   logic [COUNT_WIDTH+1:0]   diff;
   logic                     ge;
   logic [SUM_W-1:0]         sum_mag;
   logic [STRG_W-1:0]        quot8;
   logic                     out_free;
   logic [31:0]              count_ext;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;

   assign frame_hit = (req_chan.strength >= floor_ff)
                    & ((req_chan.addr_first == target_ff) | (req_chan.addr_second == target_ff))
                    & (count_ff != COUNT_FULL);

   assign elapsed_next = elapsed_ff + TICK_W'(1);
   assign sum_mag      = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   assign rem_sh = {rem_ff, dvd_ff[SUM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, count_ff};
   assign ge     = ~diff[COUNT_WIDTH+1];

   assign quot8     = dvd_ff[STRG_W-1:0];
   assign out_free  = ~rsp_valid_ff | rsp_chan.ready;
   assign count_ext = 32'(count_ff);

   always_comb begin
      state_in      = state_ff;
      target_in     = target_ff;
      floor_in      = floor_ff;
      window_in     = window_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      elapsed_in    = elapsed_ff;
      uptime_in     = uptime_ff;
      report_in     = report_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      iter_in       = iter_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_avg_in    = rsp_avg_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_report_in = rsp_report_ff;
      rsp_uptime_in = rsp_uptime_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_ADDRESS: target_in = csr_wdata[ADDR_W-1:0];
            CSR_STRENGTH_FLOOR: floor_in  = csr_wdata[STRG_W-1:0];
            CSR_WINDOW_TICKS:   window_in = csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.req_type == REQ_FRAME) begin
                  if (frame_hit) begin
                     sum_in   = sum_ff + SUM_W'(req_chan.strength);
                     count_in = count_ff + COUNT_WIDTH'(1);
                     if (count_ff == '0) begin
                        low_in  = req_chan.strength;
                        high_in = req_chan.strength;
                     end else begin
                        if (req_chan.strength < low_ff) low_in = req_chan.strength;
                        if (req_chan.strength > high_ff) high_in = req_chan.strength;
                     end
                  end
               end else begin
                  uptime_in  = uptime_ff + UPTIME_W'(1);
                  elapsed_in = elapsed_next;
                  if (elapsed_next >= window_ff) begin
                     elapsed_in = '0;
                     if (count_ff != '0) begin
                        dvd_in   = sum_mag;
                        neg_in   = sum_ff[SUM_W-1];
                        rem_in   = '0;
                        iter_in  = ITER_W'(SUM_W);
                        state_in = ST_DIVIDE;
                     end
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (iter_ff != '0) begin
               dvd_in  = {dvd_ff[SUM_W-2:0], ge};
               rem_in  = ge ? diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
               iter_in = iter_ff - ITER_W'(1);
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_avg_in    = neg_ff ? -quot8 : quot8;
               rsp_min_in    = low_ff;
               rsp_max_in    = high_ff;
               rsp_count_in  = count_ext[SCOUNT_W-1:0];
               rsp_report_in = report_ff;
               rsp_uptime_in = uptime_ff;
               report_in     = report_ff + REPORT_W'(1);
               sum_in        = '0;
               count_in      = '0;
               low_in        = '0;
               high_in       = '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= TARGET_ADDRESS_RST;
         floor_ff     <= STRENGTH_FLOOR_RST;
         window_ff    <= WINDOW_TICKS_RST;
         sum_ff       <= '0;
         count_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         elapsed_ff   <= '0;
         uptime_ff    <= '0;
         report_ff    <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         floor_ff     <= floor_in;
         window_ff    <= window_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         elapsed_ff   <= elapsed_in;
         uptime_ff    <= uptime_in;
         report_ff    <= report_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_report_ff <= rsp_report_in;
      rsp_uptime_ff <= rsp_uptime_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.avg_strength  = rsp_avg_ff;
   assign rsp_chan.min_strength  = rsp_min_ff;
   assign rsp_chan.max_strength  = rsp_max_ff;
   assign rsp_chan.sample_count  = rsp_count_ff;
   assign rsp_chan.report_number = rsp_report_ff;
   assign rsp_chan.uptime_ticks  = rsp_uptime_ff;

endmodule

`default_nettype wire
